FILE: sv/bcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants for the block container deframer.
// ----------------------------------------------------------------------------
package bcd_pkg;

  // header length in bytes; also the header position once the header is in
  localparam logic [5:0] HDR_BYTES = 6'd32;

  // magic bytes, little-endian: byte 0 in bits 7:0
  localparam logic [31:0] MAGIC_WORD = 32'h5043_324D;

  localparam logic [63:0] RST_LIMIT_U = 64'd16777216;
  localparam logic [63:0] RST_LIMIT_C = 64'd16777216;
  localparam logic [63:0] RST_LIMIT_W = 64'd33554432;
  localparam logic [15:0] RST_EXP_VER = 16'd1;

  typedef enum logic [1:0] {
    REG_LIMIT_U = 2'd0,
    REG_LIMIT_C = 2'd1,
    REG_LIMIT_W = 2'd2,
    REG_EXP_VER = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_LIMIT = 3'd1,
    ST_SHORT      = 3'd2,
    ST_MAGIC      = 3'd3,
    ST_FIELD      = 3'd4,
    ST_OVER_LIMIT = 3'd5,
    ST_LENGTH     = 3'd6
  } status_t;

  typedef struct packed {
    logic [63:0] limit_u;
    logic [63:0] limit_c;
    logic [63:0] limit_w;
    logic [15:0] exp_ver;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        done_res;
    logic [2:0]  status;
    logic        codec_id;
    logic [63:0] original_size;
    logic [63:0] payload_size;
    logic [63:0] block_checksum;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/block_container_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_container_deframer
// Checks a 32-byte block header and passes the payload bytes through.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, back to back, unless the input stalls.
// Each byte sits in the input register, where the header capture, the
// saturating payload counter and the 64-bit limit compares work on it, and
// its result (if any) enters a two-entry output queue, whose output register
// offers it. Header bytes that are not final give no result. The input
// stalls only when both queue entries are full. The final byte's result
// carries the status and header fields; a nonzero status rejects the whole
// block, including payload bytes already passed out. Registers sit at byte
// addresses 0, 8, 16, 24 with 64-bit data and may only be written while idle.
// ----------------------------------------------------------------------------
module block_container_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_final_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_done_res,
  output logic [2:0]       out_status,
  output logic             out_codec_id,
  output logic [63:0]      out_original_size,
  output logic [63:0]      out_payload_size,
  output logic [63:0]      out_block_checksum,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  bcd_pkg::cfg_t cfg;
  bcd_pkg::res_t push_res;
  bcd_pkg::res_t out_res;
  logic          push;
  logic          q_space;

  bcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcd_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .cfg           (cfg),
    .q_space       (q_space),
    .push          (push),
    .res           (push_res)
  );

  bcd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .q_space   (q_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte           = out_res.out_byte;
  assign out_byte_valid     = out_res.byte_valid;
  assign out_done_res       = out_res.done_res;
  assign out_status         = out_res.status;
  assign out_codec_id       = out_res.codec_id;
  assign out_original_size  = out_res.original_size;
  assign out_payload_size   = out_res.payload_size;
  assign out_block_checksum = out_res.block_checksum;

endmodule
`default_nettype wire

FILE: sv/bcd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_cfg_regs
// APB register file: size limits, working budget and expected version.
// ----------------------------------------------------------------------------
module bcd_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic      [63:0]   prdata,
  output logic               pready,
  output bcd_pkg::cfg_t      cfg
);

  bcd_pkg::cfg_t    cfg_r;
  bcd_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = bcd_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_u <= bcd_pkg::RST_LIMIT_U;
      cfg_r.limit_c <= bcd_pkg::RST_LIMIT_C;
      cfg_r.limit_w <= bcd_pkg::RST_LIMIT_W;
      cfg_r.exp_ver <= bcd_pkg::RST_EXP_VER;
    end else if (wr_en) begin
      unique case (idx)
        bcd_pkg::REG_LIMIT_U: cfg_r.limit_u <= pwdata;
        bcd_pkg::REG_LIMIT_C: cfg_r.limit_c <= pwdata;
        bcd_pkg::REG_LIMIT_W: cfg_r.limit_w <= pwdata;
        bcd_pkg::REG_EXP_VER: cfg_r.exp_ver <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bcd_pkg::REG_LIMIT_U: prdata = cfg_r.limit_u;
      bcd_pkg::REG_LIMIT_C: prdata = cfg_r.limit_c;
      bcd_pkg::REG_LIMIT_W: prdata = cfg_r.limit_w;
      bcd_pkg::REG_EXP_VER: prdata = {48'd0, cfg_r.exp_ver};
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/bcd_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_parse
// Input register, header capture, payload count and the final verdict.
// ----------------------------------------------------------------------------
module bcd_parse (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_final_byte,
  input  wire bcd_pkg::cfg_t cfg,
  input  wire logic          q_space,
  output logic               push,
  output bcd_pkg::res_t      res
);

  // input register
  logic        v_r;
  logic [7:0]  byte_r;
  logic        fin_r;

  // block state
  logic [5:0]  hp_r,  hp_nxt;
  logic        mag_r, mag_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [7:0]  cod_r, cod_nxt;
  logic [7:0]  flg_r, flg_nxt;
  logic [63:0] so_r,  so_nxt;
  logic [63:0] sp_r,  sp_nxt;
  logic [63:0] ck_r,  ck_nxt;
  logic [63:0] pc_r,  pc_nxt;

  logic            is_pay;
  logic            gives;
  logic            move;
  logic            accept;
  bcd_pkg::status_t st;

  assign is_pay   = (hp_r == bcd_pkg::HDR_BYTES);
  assign gives    = fin_r || is_pay;
  assign move     = v_r && (!gives || q_space);
  assign push     = move && gives;
  assign in_stall = v_r && !move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (move) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      fin_r  <= in_final_byte;
    end
  end

  always_comb begin
    hp_nxt  = hp_r;
    mag_nxt = mag_r;
    ver_nxt = ver_r;
    cod_nxt = cod_r;
    flg_nxt = flg_r;
    so_nxt  = so_r;
    sp_nxt  = sp_r;
    ck_nxt  = ck_r;
    pc_nxt  = pc_r;
    if (!is_pay) begin
      hp_nxt = hp_r + 6'd1;
      case (hp_r[4:3])
        2'd0: begin
          if (!hp_r[2]) begin
            if (bcd_pkg::MAGIC_WORD[{hp_r[1:0], 3'b000} +: 8] != byte_r) begin
              mag_nxt = 1'b0;
            end
          end else if (!hp_r[1]) begin
            ver_nxt[{hp_r[0], 3'b000} +: 8] = byte_r;
          end else if (!hp_r[0]) begin
            cod_nxt = byte_r;
          end else begin
            flg_nxt = byte_r;
          end
        end
        2'd1: so_nxt[{hp_r[2:0], 3'b000} +: 8] = byte_r;
        2'd2: sp_nxt[{hp_r[2:0], 3'b000} +: 8] = byte_r;
        default: ck_nxt[{hp_r[2:0], 3'b000} +: 8] = byte_r;
      endcase
    end else if (pc_r != '1) begin
      pc_nxt = pc_r + 64'd1;
    end
  end

  // Sizes are complete whenever the header is; a short block never reaches
  // the size checks, so the registered sizes serve.
  always_comb begin
    if (cfg.limit_u == '0 || cfg.limit_c == '0 || cfg.limit_w == '0) begin
      st = bcd_pkg::ST_ZERO_LIMIT;
    end else if (hp_nxt != bcd_pkg::HDR_BYTES) begin
      st = bcd_pkg::ST_SHORT;
    end else if (!mag_nxt) begin
      st = bcd_pkg::ST_MAGIC;
    end else if (ver_nxt != cfg.exp_ver || cod_nxt > 8'd1 || flg_nxt != 8'd0) begin
      st = bcd_pkg::ST_FIELD;
    end else if (so_r > cfg.limit_u || sp_r > cfg.limit_c || pc_nxt > cfg.limit_c) begin
      st = bcd_pkg::ST_OVER_LIMIT;
    end else if (pc_nxt != sp_r) begin
      st = bcd_pkg::ST_LENGTH;
    end else begin
      st = bcd_pkg::ST_OK;
    end
  end

  always_comb begin
    res = '0;
    if (is_pay) begin
      res.out_byte   = byte_r;
      res.byte_valid = 1'b1;
    end
    if (fin_r) begin
      res.done_res       = 1'b1;
      res.status         = st;
      res.codec_id       = (cod_nxt <= 8'd1) ? cod_nxt[0] : 1'b0;
      res.original_size  = so_nxt;
      res.payload_size   = sp_nxt;
      res.block_checksum = ck_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (move && fin_r)) begin
      hp_r  <= '0;
      mag_r <= 1'b1;
      ver_r <= '0;
      cod_r <= '0;
      flg_r <= '0;
      so_r  <= '0;
      sp_r  <= '0;
      ck_r  <= '0;
      pc_r  <= '0;
    end else if (move) begin
      hp_r  <= hp_nxt;
      mag_r <= mag_nxt;
      ver_r <= ver_nxt;
      cod_r <= cod_nxt;
      flg_r <= flg_nxt;
      so_r  <= so_nxt;
      sp_r  <= sp_nxt;
      ck_r  <= ck_nxt;
      pc_r  <= pc_nxt;
    end
  end

  a_hp_range: assert property (@(posedge clk) disable iff (!rst_n)
    hp_r <= bcd_pkg::HDR_BYTES)
    else $error("header position past header length");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (move && fin_r) |=> (hp_r == 6'd0 && pc_r == 64'd0 && mag_r))
    else $error("block state not cleared after final item");

  a_count_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    !is_pay |-> pc_r == 64'd0)
    else $error("payload counted during header");

endmodule
`default_nettype wire

FILE: sv/bcd_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_out_queue
// Two-entry result queue: output register plus skid entry.
// ----------------------------------------------------------------------------
module bcd_out_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bcd_pkg::res_t push_res,
  output logic               q_space,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bcd_pkg::res_t      out_res
);

  bcd_pkg::res_t q0_r, q1_r;
  logic [1:0]    cnt_r;
  logic          pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign q_space   = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = q0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0_r <= (push && cnt_r == 2'd1) ? push_res : q1_r;
    end else if (push && cnt_r == 2'd0) begin
      q0_r <= push_res;
    end
    if (push && ((cnt_r == 2'd1 && !pop) || (cnt_r == 2'd2 && pop))) begin
      q1_r <= push_res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("result pushed into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule
`default_nettype wire
